### rtl/hps_pkg.sv
package hps_pkg;

    // fixed point formats
    localparam int LIN_FRAC_BITS   = 16;
    localparam int SCALE_FRAC_BITS = 13;
    localparam int WORD_W          = 32;
    localparam int BYTE_W          = 8;
    localparam int CFG_W           = 15;
    localparam int CFG_IDX_W       = 2;
    localparam int FMT_W           = 2;
    // linear value up to 100.0 needs seven integer bits
    localparam int LIN_W           = LIN_FRAC_BITS + 7;
    // scaled value clamped to 1.0
    localparam int UNIT_W          = LIN_FRAC_BITS + 1;

    localparam logic [LIN_W-1:0]  SAT_LIN       = LIN_W'(100) << LIN_FRAC_BITS;
    localparam logic [UNIT_W-1:0] ONE_LIN       = UNIT_W'(1) << LIN_FRAC_BITS;
    localparam logic [CFG_W-1:0]  INV_SCALE_RST = CFG_W'(1) << SCALE_FRAC_BITS;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE  = 8'hFF;

    // fp16 decoding
    localparam logic [4:0] HALF_EXP_MAX = 5'h1F;
    localparam logic [4:0] HALF_EXP_SAT = 5'd22;
    localparam int         HALF_W       = 31;
    localparam int         HALF_RSH     = 24 - LIN_FRAC_BITS;

    // fp32 decoding
    localparam logic [7:0] FP32_EXP_MAX = 8'hFF;
    localparam logic [7:0] FP32_EXP_SAT = 8'd134;
    localparam logic [8:0] FP32_POINT   = 9'd150;

    typedef enum logic [FMT_W-1:0] {
        FMT_FP16  = 2'd0,
        FMT_FP32  = 2'd1,
        FMT_BGRA8 = 2'd2
    } t_pix_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT    = 2'd0,
        CFG_HDR_DESKTOP     = 2'd1,
        CFG_INV_WHITE_SCALE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [FMT_W-1:0] fmt;
        logic             hdr;
    } t_conv_ctl;

    typedef struct packed {
        logic [BYTE_W-1:0] alpha;
        logic              first;
        logic              last;
    } t_side;

    // srgb curve constants, power segment as ratio num / 53805
    localparam int    BIG_W         = 384;
    localparam int    POW_DEN       = 53805;
    localparam int    POW_STEP      = 200;
    localparam int    POW_ENC_BASE  = 2705;
    localparam int    POW_DEC_BASE  = 2805;
    localparam int    LIN_SEG_LAST  = 10;
    localparam longint LIN_ENC_MUL  = 65892;
    localparam longint LIN_DEC_DEN  = 32946;

    typedef logic [BIG_W-1:0] t_big;
    typedef logic [255:1][UNIT_W-1:0] t_thr_tbl;
    typedef logic [255:0][UNIT_W-1:0] t_dec_tbl;

    function automatic t_big big_pow(t_big base, int n);
        t_big acc;
        acc = t_big'(1);
        for (int k = 0; k < n; k++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    localparam t_big DEN12 = big_pow(t_big'(POW_DEN), 12);

    // sign of (x / 2^L)^(1/2.4) - num / 53805, compared as exact integers
    function automatic int pow_cmp(longint x, longint num);
        t_big a;
        t_big b;
        a = big_pow(t_big'(x), 5) * DEN12;
        b = big_pow(t_big'(num), 12) << (5 * LIN_FRAC_BITS);
        if (a > b) return 1;
        if (a < b) return -1;
        return 0;
    endfunction

    function automatic bit reaches(longint x, int i);
        longint rhs;
        rhs = longint'((2 * i - 1) * 10) << LIN_FRAC_BITS;
        if (i <= LIN_SEG_LAST) return (x * LIN_ENC_MUL) >= rhs;
        return pow_cmp(x, longint'(POW_STEP * i + POW_ENC_BASE)) >= 0;
    endfunction

    // smallest linear value that encodes to at least code i
    function automatic logic [UNIT_W-1:0] enc_threshold(int i);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = longint'(ONE_LIN);
        for (int k = 0; k < UNIT_W + 1; k++) begin
            if (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (reaches(mid, i)) hi = mid;
                else lo = mid + 1;
            end
        end
        return UNIT_W'(lo);
    endfunction

    function automatic logic [UNIT_W-1:0] dec_value(int c);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = longint'(ONE_LIN);
        if (c <= LIN_SEG_LAST) begin
            return UNIT_W'((longint'(c * 10) << LIN_FRAC_BITS) / LIN_DEC_DEN);
        end
        for (int k = 0; k < UNIT_W + 1; k++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (pow_cmp(mid, longint'(POW_STEP * c + POW_DEC_BASE)) <= 0) lo = mid;
                else hi = mid - 1;
            end
        end
        return UNIT_W'(lo);
    endfunction

    function automatic t_thr_tbl build_thr_tbl();
        t_thr_tbl tbl;
        for (int i = 1; i < 256; i++) begin
            tbl[i] = enc_threshold(i);
        end
        return tbl;
    endfunction

    function automatic t_dec_tbl build_dec_tbl();
        t_dec_tbl tbl;
        for (int c = 0; c < 256; c++) begin
            tbl[c] = dec_value(c);
        end
        return tbl;
    endfunction

    localparam t_thr_tbl ENC_THR = build_thr_tbl();
    localparam t_dec_tbl DEC_LIN = build_dec_tbl();

endpackage

### rtl/hdr_pixel_to_srgb8_top.sv
// hdr pixel to srgb8 converter: takes one pixel per transaction (fp16 or fp32 scrgb
// channels, or bgra8 bytes) and returns one bgra8 pixel per transaction, in order.
// float channels are cleaned up (nan and negatives to zero, above 100 saturates),
// converted to fixed point, scaled by inv_white_scale, clamped to 1.0 and encoded
// to srgb bytes with alpha 255. bgra8 on an hdr desktop is linearized through a
// 256-entry table first; on an sdr desktop bgra8 passes through unchanged. a
// running frame_black flag restarts on first_pixel; frame_end copies last_pixel.
// throughput is one pixel per clock while i_out_ready holds; a pixel passes
// through the two register stages (input, then output) with all conversion
// done combinationally between them. the input register loads whenever it is
// empty or the output register loads, so a stalled output holds at most two
// pixels. configuration must be written only while idle; the block itself
// does not enforce this.
module hdr_pixel_to_srgb8_top import hps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input pixel channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [WORD_W-1:0]    i_red_word,
    input  logic [WORD_W-1:0]    i_green_word,
    input  logic [WORD_W-1:0]    i_blue_word,
    input  logic [BYTE_W-1:0]    i_alpha_byte,
    input  logic                 i_first_pixel,
    input  logic                 i_last_pixel,
    // output pixel channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_out_blue,
    output logic [BYTE_W-1:0]    o_out_green,
    output logic [BYTE_W-1:0]    o_out_red,
    output logic [BYTE_W-1:0]    o_out_alpha,
    output logic                 o_frame_black,
    output logic                 o_frame_end
);

    localparam int NCH    = 3;
    localparam int CH_RED = 0;
    localparam int CH_GRN = 1;
    localparam int CH_BLU = 2;

    // configuration registers
    logic [FMT_W-1:0] r_pixel_format;
    logic             r_hdr_desktop;
    logic [CFG_W-1:0] r_inv_white_scale;

    // stage valids and black flag
    logic r_v1;
    logic r_vo;
    logic r_black;

    // stage payloads
    logic [WORD_W-1:0] r_s1_word [NCH];
    t_side             r_s1_side;
    logic [BYTE_W-1:0] r_out_byte [NCH];
    logic [BYTE_W-1:0] r_out_alpha;
    logic              r_out_black;
    logic              r_out_end;

    logic [LIN_W-1:0]  w_lin [NCH];
    logic [UNIT_W-1:0] w_y   [NCH];
    logic [BYTE_W-1:0] w_enc [NCH];
    logic [BYTE_W-1:0] n_out_byte [NCH];
    logic [BYTE_W-1:0] n_out_alpha;
    logic              n_black;
    t_conv_ctl         w_ctl;
    t_side             w_in_side;
    logic              w_pass;
    logic              w_en1;
    logic              w_eno;

    // each stage loads when it is empty or the next stage loads too
    assign w_eno      = !r_vo || i_out_ready;
    assign w_en1      = !r_v1 || w_eno;
    assign o_in_ready = w_en1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format    <= FMT_FP16;
            r_hdr_desktop     <= 1'b0;
            r_inv_white_scale <= INV_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PIXEL_FORMAT:    r_pixel_format    <= i_cfg_data[FMT_W-1:0];
                CFG_HDR_DESKTOP:     r_hdr_desktop     <= i_cfg_data[0];
                CFG_INV_WHITE_SCALE: r_inv_white_scale <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_vo    <= 1'b0;
            r_black <= 1'b1;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_eno) r_vo <= r_v1;
            // black state follows results in order, one update per pixel
            if (w_eno && r_v1) r_black <= n_black;
        end
    end

    // input register
    assign w_in_side.alpha = i_alpha_byte;
    assign w_in_side.first = i_first_pixel;
    assign w_in_side.last  = i_last_pixel;

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in_valid) begin
            r_s1_word[CH_RED] <= i_red_word;
            r_s1_word[CH_GRN] <= i_green_word;
            r_s1_word[CH_BLU] <= i_blue_word;
            r_s1_side         <= w_in_side;
        end
    end

    // format decode, white scaling and encoding in one pass
    assign w_ctl.fmt = r_pixel_format;
    assign w_ctl.hdr = r_hdr_desktop;
    assign w_pass    = (r_pixel_format != FMT_FP16) && (r_pixel_format != FMT_FP32)
                       && !r_hdr_desktop;

    for (genvar gc = 0; gc < NCH; gc++) begin : g_ch
        hps_lin u_lin (
            .i_word (r_s1_word[gc]),
            .i_ctl  (w_ctl),
            .o_lin  (w_lin[gc])
        );

        hps_scale u_scale (
            .i_lin       (w_lin[gc]),
            .i_inv_scale (r_inv_white_scale),
            .o_y         (w_y[gc])
        );

        hps_enc u_enc (
            .i_y    (w_y[gc]),
            .o_byte (w_enc[gc])
        );

        // sdr bgra8 passthrough bypasses the encoder
        assign n_out_byte[gc] = w_pass ? r_s1_word[gc][BYTE_W-1:0] : w_enc[gc];

        always_ff @(posedge i_clk) begin
            if (w_eno && r_v1) begin
                r_out_byte[gc] <= n_out_byte[gc];
            end
        end
    end

    // output stage: alpha, black detection
    assign n_out_alpha = w_pass ? r_s1_side.alpha : ALPHA_OPAQUE;
    assign n_black     = (r_s1_side.first || r_black)
                         && (n_out_byte[CH_RED] == '0)
                         && (n_out_byte[CH_GRN] == '0)
                         && (n_out_byte[CH_BLU] == '0);

    always_ff @(posedge i_clk) begin
        if (w_eno && r_v1) begin
            r_out_alpha <= n_out_alpha;
            r_out_black <= n_black;
            r_out_end   <= r_s1_side.last;
        end
    end

    assign o_out_valid   = r_vo;
    assign o_out_blue    = r_out_byte[CH_BLU];
    assign o_out_green   = r_out_byte[CH_GRN];
    assign o_out_red     = r_out_byte[CH_RED];
    assign o_out_alpha   = r_out_alpha;
    assign o_frame_black = r_out_black;
    assign o_frame_end   = r_out_end;

endmodule

### rtl/hps_lin.sv
// one channel: fp16, fp32 or byte word to linear fixed point
module hps_lin import hps_pkg::*; (
    input  logic [WORD_W-1:0] i_word,
    input  t_conv_ctl         i_ctl,
    output logic [LIN_W-1:0]  o_lin
);

    logic [4:0]        w_he;
    logic [10:0]       w_hman;
    logic [4:0]        w_hsh;
    logic [HALF_W-1:0] w_hval;
    logic [LIN_W-1:0]  w_half_lin;

    logic [7:0]        w_se;
    logic [23:0]       w_sman;
    logic [8:0]        w_st;
    logic [WORD_W-1:0] w_sval;
    logic [LIN_W-1:0]  w_single_lin;

    // fp16
    assign w_he   = i_word[14:10];
    assign w_hman = {(w_he != 5'd0), i_word[9:0]};
    assign w_hsh  = (w_he == 5'd0) ? 5'd0 : (w_he - 5'd1);
    assign w_hval = (HALF_W'(w_hman) << w_hsh) >> HALF_RSH;

    always_comb begin
        if (w_he == HALF_EXP_MAX) begin
            w_half_lin = ((i_word[9:0] != 10'd0) || i_word[15]) ? '0 : SAT_LIN;
        end else if (i_word[15]) begin
            w_half_lin = '0;
        end else if (w_he >= HALF_EXP_SAT) begin
            w_half_lin = SAT_LIN;
        end else if (w_hval > HALF_W'(SAT_LIN)) begin
            w_half_lin = SAT_LIN;
        end else begin
            w_half_lin = LIN_W'(w_hval);
        end
    end

    // fp32
    assign w_se   = i_word[30:23];
    assign w_sman = {(w_se != 8'd0), i_word[22:0]};
    assign w_st   = ((w_se == 8'd0) ? 9'd1 : {1'b0, w_se}) + 9'(LIN_FRAC_BITS);
    assign w_sval = (w_st >= FP32_POINT) ? (WORD_W'(w_sman) << (w_st - FP32_POINT))
                                         : (WORD_W'(w_sman) >> (FP32_POINT - w_st));

    always_comb begin
        if (w_se == FP32_EXP_MAX) begin
            w_single_lin = ((i_word[22:0] != 23'd0) || i_word[31]) ? '0 : SAT_LIN;
        end else if (i_word[31]) begin
            w_single_lin = '0;
        end else if (w_se >= FP32_EXP_SAT) begin
            w_single_lin = SAT_LIN;
        end else if (w_sval > WORD_W'(SAT_LIN)) begin
            w_single_lin = SAT_LIN;
        end else begin
            w_single_lin = LIN_W'(w_sval);
        end
    end

    always_comb begin
        unique case (i_ctl.fmt)
            FMT_FP16: o_lin = w_half_lin;
            FMT_FP32: o_lin = w_single_lin;
            default:  o_lin = LIN_W'(DEC_LIN[i_word[7:0]]);
        endcase
    end

endmodule

### rtl/hps_scale.sv
// white scaling and clamp to 1.0
module hps_scale import hps_pkg::*; (
    input  logic [LIN_W-1:0]  i_lin,
    input  logic [CFG_W-1:0]  i_inv_scale,
    output logic [UNIT_W-1:0] o_y
);

    logic [LIN_W+CFG_W-1:0] w_prod;
    logic [LIN_W+CFG_W-1:0] w_shr;

    assign w_prod = (LIN_W + CFG_W)'(i_lin) * (LIN_W + CFG_W)'(i_inv_scale);
    assign w_shr  = w_prod >> SCALE_FRAC_BITS;
    assign o_y    = (w_shr > (LIN_W + CFG_W)'(ONE_LIN)) ? ONE_LIN : UNIT_W'(w_shr);

endmodule

### rtl/hps_enc.sv
// srgb encoding by compare against 255 decision thresholds
module hps_enc import hps_pkg::*; (
    input  logic [UNIT_W-1:0] i_y,
    output logic [BYTE_W-1:0] o_byte
);

    logic [255:1] w_ge;

    for (genvar gi = 1; gi < 256; gi++) begin : g_thr
        assign w_ge[gi] = (i_y >= ENC_THR[gi]);
    end

    // thresholds rise with the code, so the ge vector is a thermometer
    always_comb begin
        logic [BYTE_W-1:0] v_acc;
        logic [BYTE_W-1:0] v_cand;
        v_acc = '0;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            v_cand = v_acc | (BYTE_W'(1) << b);
            if (w_ge[v_cand]) begin
                v_acc = v_cand;
            end
        end
        o_byte = v_acc;
    end

endmodule

### sim/tb_hdr_pixel_to_srgb8_top.sv
`timescale 1ns / 1ps

import hps_pkg::*;

// srgb curve ratios, power segment as num / 53805
localparam longint unsigned CURVE_DEN     = 53805;
localparam longint unsigned CURVE_STEP    = 200;
localparam longint unsigned CURVE_ENC_OFS = 2705;
localparam longint unsigned CURVE_DEC_OFS = 2805;
localparam longint unsigned TOE_ENC_MUL   = 65892;
localparam longint unsigned TOE_DEC_DEN   = 32946;
localparam int              TOE_LAST      = 10;

typedef struct {
    logic [WORD_W-1:0] red;
    logic [WORD_W-1:0] green;
    logic [WORD_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic              first_px;
    logic              last_px;
} t_pixel_in;

typedef struct {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] alpha;
    logic              black;
    logic              frame_end;
} t_pixel_out;

class srgb_pixel_check;
    logic [FMT_W-1:0]  fmt;
    logic              hdr;
    logic [CFG_W-1:0]  inv_scale;
    logic              black_run;
    // smallest linear value that reaches each code, and linear value of each byte
    logic [UNIT_W-1:0] code_floor [1:255];
    logic [UNIT_W-1:0] byte_linear [0:255];
    t_pixel_out        pending_bgra [$];
    int                errors;

    function new();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        bit              hit;
        fmt       = FMT_FP16;
        hdr       = 1'b0;
        inv_scale = INV_SCALE_RST;
        black_run = 1'b1;
        errors    = 0;
        for (int i = 1; i < 256; i++) begin
            lo = 0;
            hi = longint'(ONE_LIN);
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (i <= TOE_LAST)
                    hit = mid * TOE_ENC_MUL >= (longint'((2 * i - 1) * 10) << LIN_FRAC_BITS);
                else
                    hit = curve_order(mid, CURVE_STEP * i + CURVE_ENC_OFS) >= 0;
                if (hit) hi = mid;
                else lo = mid + 1;
            end
            code_floor[i] = UNIT_W'(lo);
        end
        for (int c = 0; c < 256; c++) begin
            if (c <= TOE_LAST) begin
                byte_linear[c] = UNIT_W'((longint'(c * 10) << LIN_FRAC_BITS) / TOE_DEC_DEN);
            end else begin
                lo = 0;
                hi = longint'(ONE_LIN);
                while (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    if (curve_order(mid, CURVE_STEP * c + CURVE_DEC_OFS) <= 0) lo = mid;
                    else hi = mid - 1;
                end
                byte_linear[c] = UNIT_W'(lo);
            end
        end
    endfunction

    // exact sign of x^5 * den^12 - num^12 * 2^(5L)
    function int curve_order(logic [63:0] x, logic [63:0] num);
        logic [383:0] lhs;
        logic [383:0] rhs;
        lhs = 384'd1;
        rhs = 384'd1;
        for (int k = 0; k < 5; k++) lhs = lhs * x;
        for (int k = 0; k < 12; k++) begin
            lhs = lhs * CURVE_DEN;
            rhs = rhs * num;
        end
        rhs = rhs << (5 * LIN_FRAC_BITS);
        if (lhs > rhs) return 1;
        if (lhs < rhs) return -1;
        return 0;
    endfunction

    function void set_config(logic [FMT_W-1:0] f, logic h, logic [CFG_W-1:0] s);
        fmt       = f;
        hdr       = h;
        inv_scale = s;
    endfunction

    function int pending();
        return pending_bgra.size();
    endfunction

    // channel word to linear fixed point, float paths cleaned up and saturated
    function logic [LIN_W-1:0] to_linear(logic [WORD_W-1:0] word);
        logic [4:0]  hexp;
        logic [10:0] hman;
        logic [7:0]  sexp;
        logic [23:0] sman;
        logic [63:0] v;
        int          sh;
        if (fmt == FMT_FP16) begin
            hexp = word[14:10];
            hman = {1'b0, word[9:0]};
            if (hexp == 5'h1F) return (word[9:0] != 0 || word[15]) ? '0 : SAT_LIN;
            if (word[15]) return '0;
            if (hexp == 0) hexp = 5'd1;
            else hman[10] = 1'b1;
            if (hexp >= 5'd22) return SAT_LIN;
            sh = int'(hexp) - 25 + LIN_FRAC_BITS;
            if (sh >= 0) v = 64'(hman) << sh;
            else v = 64'(hman) >> (-sh);
        end else if (fmt == FMT_FP32) begin
            sexp = word[30:23];
            sman = {1'b0, word[22:0]};
            if (sexp == 8'hFF) return (word[22:0] != 0 || word[31]) ? '0 : SAT_LIN;
            if (word[31]) return '0;
            if (sexp == 0) sexp = 8'd1;
            else sman[23] = 1'b1;
            if (sexp >= 8'd134) return SAT_LIN;
            sh = int'(sexp) - 150 + LIN_FRAC_BITS;
            if (sh >= 0) v = 64'(sman) << sh;
            else if (-sh >= 32) v = 0;
            else v = 64'(sman) >> (-sh);
        end else begin
            v = 64'(byte_linear[word[7:0]]);
        end
        return (v > 64'(SAT_LIN)) ? SAT_LIN : LIN_W'(v);
    endfunction

    function logic [BYTE_W-1:0] encode_scaled(logic [LIN_W-1:0] lin);
        logic [63:0] y;
        logic [8:0]  code;
        logic [8:0]  trial;
        y = (64'(lin) * 64'(inv_scale)) >> SCALE_FRAC_BITS;
        if (y > 64'(ONE_LIN)) y = 64'(ONE_LIN);
        code = '0;
        for (int b = 7; b >= 0; b--) begin
            trial = code | (9'd1 << b);
            if (y >= 64'(code_floor[trial])) code = trial;
        end
        return code[7:0];
    endfunction

    function void pixel_accepted(t_pixel_in px);
        t_pixel_out e;
        if (fmt == FMT_FP16 || fmt == FMT_FP32 || hdr) begin
            e.red   = encode_scaled(to_linear(px.red));
            e.green = encode_scaled(to_linear(px.green));
            e.blue  = encode_scaled(to_linear(px.blue));
            e.alpha = ALPHA_OPAQUE;
        end else begin
            e.red   = px.red[7:0];
            e.green = px.green[7:0];
            e.blue  = px.blue[7:0];
            e.alpha = px.alpha;
        end
        if (px.first_px) black_run = 1'b1;
        if ({e.red, e.green, e.blue} != 0) black_run = 1'b0;
        e.black     = black_run;
        e.frame_end = px.last_px;
        pending_bgra.push_back(e);
    endfunction

    function void compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
        end
    endfunction

    function void bgra_returned(t_pixel_out got);
        t_pixel_out e;
        if (pending_bgra.size() == 0) begin
            $error("output transaction with no pixel outstanding");
            errors++;
            return;
        end
        e = pending_bgra.pop_front();
        compare_field("out_blue", e.blue, got.blue);
        compare_field("out_green", e.green, got.green);
        compare_field("out_red", e.red, got.red);
        compare_field("out_alpha", e.alpha, got.alpha);
        compare_field("frame_black", BYTE_W'(e.black), BYTE_W'(got.black));
        compare_field("frame_end", BYTE_W'(e.frame_end), BYTE_W'(got.frame_end));
    endfunction
endclass

module tb_hdr_pixel_to_srgb8_top;

    // unused format code, the block decodes it as bytes
    localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;
    localparam logic [CFG_W-1:0] SCALE_MAX = {CFG_W{1'b1}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [WORD_W-1:0]    i_red_word;
    logic [WORD_W-1:0]    i_green_word;
    logic [WORD_W-1:0]    i_blue_word;
    logic [BYTE_W-1:0]    i_alpha_byte;
    logic                 i_first_pixel;
    logic                 i_last_pixel;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BYTE_W-1:0]    o_out_blue;
    logic [BYTE_W-1:0]    o_out_green;
    logic [BYTE_W-1:0]    o_out_red;
    logic [BYTE_W-1:0]    o_out_alpha;
    logic                 o_frame_black;
    logic                 o_frame_end;

    srgb_pixel_check sb;
    t_pixel_out      out_px;
    // set for phases where the sender never idles
    bit              no_idle;

    hdr_pixel_to_srgb8_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_red_word    (i_red_word),
        .i_green_word  (i_green_word),
        .i_blue_word   (i_blue_word),
        .i_alpha_byte  (i_alpha_byte),
        .i_first_pixel (i_first_pixel),
        .i_last_pixel  (i_last_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_blue    (o_out_blue),
        .o_out_green   (o_out_green),
        .o_out_red     (o_out_red),
        .o_out_alpha   (o_out_alpha),
        .o_frame_black (o_frame_black),
        .o_frame_end   (o_frame_end)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random channel word for the given format; dark words always encode to zero
    function automatic logic [WORD_W-1:0] random_channel(logic [FMT_W-1:0] fmt, bit dark);
        int                pick;
        logic [WORD_W-1:0] w;
        pick = $urandom_range(0, 9);
        w    = $urandom;
        if (fmt == FMT_FP16) begin
            if (dark) begin
                // negatives, negative nan and zero all land on black
                if (pick < 5) w[15] = 1'b1;
                else w[15:0] = 16'h0000;
            end else if (pick >= 2 && pick <= 6) begin
                // values below 4.0, mostly below 2.0, where the curve matters
                w[15:0] = {1'b0, 5'($urandom_range(0, 16)), w[9:0]};
            end else if (pick == 7) begin
                case ($urandom_range(0, 7))
                    0: w[15:0] = 16'h7C00;
                    1: w[15:0] = 16'hFC00;
                    2: w[15:0] = 16'h7E00;
                    3: w[15:0] = 16'h8000;
                    4: w[15:0] = 16'h0000;
                    5: w[15:0] = 16'h5640;
                    6: w[15:0] = 16'h7BFF;
                    default: w[15:0] = 16'h0001;
                endcase
            end else if (pick >= 8) begin
                w[15]    = 1'b0;
                w[14:10] = 5'($urandom_range(0, 30));
            end
        end else if (fmt == FMT_FP32) begin
            if (dark) begin
                if (pick < 5) w[31] = 1'b1;
                else w = '0;
            end else if (pick >= 2 && pick <= 6) begin
                w = {1'b0, 8'($urandom_range(100, 127)), w[22:0]};
            end else if (pick == 7) begin
                case ($urandom_range(0, 7))
                    0: w = 32'h7F80_0000;
                    1: w = 32'hFF80_0000;
                    2: w = 32'h7FC0_0000;
                    3: w = 32'h8000_0000;
                    4: w = 32'h0000_0000;
                    5: w = 32'h42C8_0000;
                    6: w = 32'h7F7F_FFFF;
                    default: w = 32'h0000_0001;
                endcase
            end else if (pick >= 8) begin
                w[31]    = 1'b0;
                w[30:23] = 8'($urandom_range(0, 140));
            end
        end else if (dark) begin
            w[7:0] = 8'h00;
        end
        return w;
    endfunction

    // one input transaction; valid stays up across back-to-back pixels
    task automatic send_rgb(input logic [WORD_W-1:0] r, input logic [WORD_W-1:0] g,
                            input logic [WORD_W-1:0] b, input logic [BYTE_W-1:0] a,
                            input logic first_px, input logic last_px);
        t_pixel_in px;
        int        gap;
        px.red      = r;
        px.green    = g;
        px.blue     = b;
        px.alpha    = a;
        px.first_px = first_px;
        px.last_px  = last_px;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_red_word    <= r;
        i_green_word  <= g;
        i_blue_word   <= b;
        i_alpha_byte  <= a;
        i_first_pixel <= first_px;
        i_last_pixel  <= last_px;
        do @(posedge i_clk); while (!o_in_ready);
        sb.pixel_accepted(px);
    endtask

    // stop sending and wait until every expected pixel has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // all three registers, written back to back while the block is empty
    task automatic write_settings(input logic [FMT_W-1:0] fmt, input logic hdr,
                                  input logic [CFG_W-1:0] scale);
        logic [CFG_W-1:0] junk;
        drain_results();
        // let the pipeline settle past its latency
        repeat (4) @(posedge i_clk);
        junk = CFG_W'($urandom);
        // upper data bits of the narrow registers are don't-care
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PIXEL_FORMAT;
        i_cfg_data <= {junk[CFG_W-1:FMT_W], fmt};
        @(posedge i_clk);
        junk = CFG_W'($urandom);
        i_cfg_idx  <= CFG_HDR_DESKTOP;
        i_cfg_data <= {junk[CFG_W-1:1], hdr};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INV_WHITE_SCALE;
        i_cfg_data <= scale;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_config(fmt, hdr, scale);
    endtask

    // frames of random length, a share of them dark, a few with broken markers
    task automatic run_random_phase(input int n_items);
        int left;
        int len;
        bit dark;
        bit broken;
        bit px_dark;
        logic first_px;
        logic last_px;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(1, 12);
            if (len > left) len = left;
            dark   = ($urandom_range(0, 3) == 0);
            broken = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++) begin
                // an odd bright pixel clears the flag mid-frame
                px_dark  = dark && ($urandom_range(0, 19) != 0);
                first_px = broken ? 1'($urandom_range(0, 1)) : (k == 0);
                last_px  = broken ? 1'($urandom_range(0, 1)) : (k == len - 1);
                send_rgb(random_channel(sb.fmt, px_dark), random_channel(sb.fmt, px_dark),
                         random_channel(sb.fmt, px_dark), 8'($urandom), first_px, last_px);
            end
            left -= len;
        end
    endtask

    // output monitor, samples the handshake at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_px.blue      = o_out_blue;
            out_px.green     = o_out_green;
            out_px.red       = o_out_red;
            out_px.alpha     = o_out_alpha;
            out_px.black     = o_frame_black;
            out_px.frame_end = o_frame_end;
            sb.bgra_returned(out_px);
        end
    end

    // output side: ready held for a while, then dropped for a random stall
    initial begin
        int hold;
        int gap;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            i_out_ready <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
            repeat (hold) @(posedge i_clk);
            gap = idle_len();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #15_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [FMT_W-1:0] fmt;
        logic             hdr;
        logic [CFG_W-1:0] scale;
        sb = new();
        no_idle = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_PIXEL_FORMAT;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_red_word    <= '0;
        i_green_word  <= '0;
        i_blue_word   <= '0;
        i_alpha_byte  <= '0;
        i_first_pixel <= 1'b0;
        i_last_pixel  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fp16 at reset settings: zero, one, infinities, nan, negative zero,
        // subnormals, 100, largest finite, ignored upper bits, toe of the curve
        send_rgb(32'h0000, 32'h0000, 32'h0000, 8'h00, 1'b1, 1'b0);
        send_rgb(32'h3C00, 32'h7C00, 32'hFC00, 8'hFF, 1'b0, 1'b0);
        send_rgb(32'h7E00, 32'h8000, 32'h0001, 8'h00, 1'b0, 1'b0);
        send_rgb(32'h5640, 32'h7BFF, 32'hFFFF_03FF, 8'hFF, 1'b0, 1'b0);
        send_rgb(32'h1A6A, 32'h2E66, 32'h3800, 8'h00, 1'b0, 1'b1);
        // a one-pixel black frame, then a pixel with no first marker keeps accumulating
        send_rgb(32'h0000, 32'h0000, 32'h0000, 8'h00, 1'b1, 1'b1);
        send_rgb(32'hABCD_0000, 32'h8000, 32'hFC00, 8'h00, 1'b0, 1'b1);

        // fp32 at the largest scale
        write_settings(FMT_FP32, 1'b0, SCALE_MAX);
        send_rgb(32'h3F80_0000, 32'h7F80_0000, 32'hFF80_0000, 8'h00, 1'b1, 1'b0);
        send_rgb(32'h7FC0_0000, 32'h8000_0000, 32'h0000_0001, 8'hFF, 1'b0, 1'b0);
        send_rgb(32'h42C8_0000, 32'h7F7F_FFFF, 32'h3B4D_2E1C, 8'h00, 1'b0, 1'b0);
        send_rgb(32'h3E00_0000, 32'h3E80_0000, 32'hBF80_0000, 8'hFF, 1'b0, 1'b1);

        // bytes on an hdr desktop, both sides of the linear toe
        write_settings(FMT_BGRA8, 1'b1, INV_SCALE_RST);
        send_rgb(32'd0, 32'd10, 32'd11, 8'h33, 1'b1, 1'b0);
        send_rgb(32'd255, 32'd128, 32'hFFFF_FF01, 8'h00, 1'b0, 1'b1);

        // sdr passthrough keeps alpha; zero scale has no effect here
        write_settings(FMT_BGRA8, 1'b0, '0);
        send_rgb(32'h1234_5600, 32'hFFFF_FF00, 32'h0, 8'h5A, 1'b1, 1'b0);
        send_rgb(32'hFF, 32'h12, 32'h80, 8'h00, 1'b0, 1'b1);

        // spare format code behaves as bytes; zero scale blacks out hdr bytes
        write_settings(FMT_SPARE, 1'b1, '0);
        send_rgb(32'd255, 32'd255, 32'd255, 8'hC3, 1'b1, 1'b1);
        write_settings(FMT_SPARE, 1'b0, SCALE_MAX);
        send_rgb(32'd1, 32'd0, 32'd0, 8'h7F, 1'b1, 1'b1);

        // random phases: fixed corners first, then random settings
        for (int p = 0; p < 14; p++) begin
            case (p)
                0: begin fmt = FMT_FP16;  hdr = 1'b0; scale = INV_SCALE_RST; end
                1: begin fmt = FMT_FP32;  hdr = 1'b1; scale = INV_SCALE_RST; end
                2: begin fmt = FMT_BGRA8; hdr = 1'b1; scale = INV_SCALE_RST; end
                3: begin fmt = FMT_BGRA8; hdr = 1'b0; scale = CFG_W'($urandom); end
                4: begin fmt = FMT_FP16;  hdr = 1'b1; scale = SCALE_MAX; end
                5: begin fmt = FMT_FP32;  hdr = 1'b0; scale = '0; end
                6: begin fmt = FMT_SPARE; hdr = 1'b1; scale = CFG_W'($urandom); end
                7: begin fmt = FMT_SPARE; hdr = 1'b0; scale = CFG_W'(1); end
                default: begin
                    fmt = FMT_W'($urandom_range(0, 3));
                    hdr = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 5))
                        0: scale = '0;
                        1: scale = SCALE_MAX;
                        2: scale = INV_SCALE_RST;
                        default: scale = CFG_W'($urandom);
                    endcase
                end
            endcase
            write_settings(fmt, hdr, scale);
            // every fifth phase runs the sender flat out
            no_idle = (p % 5 == 4);
            run_random_phase(140);
            if (p == 9) begin
                // sender holds off until the block has emptied, then resumes
                drain_results();
                run_random_phase(40);
            end
        end
        no_idle = 1'b0;

        drain_results();
        // catch any stray output past the pipeline depth
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### hdr_pixel_to_srgb8_top.f
rtl/hps_pkg.sv
rtl/hps_lin.sv
rtl/hps_scale.sv
rtl/hps_enc.sv
rtl/hdr_pixel_to_srgb8_top.sv
sim/tb_hdr_pixel_to_srgb8_top.sv
